// ===== sv/pem_pkg.sv =====
// Shared constants, codes and control types for the patch embedding MAC.
// No dependencies; every other file of the block imports this package.
package pem_pkg;

   // Default geometry of a patch and the number of projected output channels.
   localparam int PROJ_CH_DEF        = 64;
   localparam int CHANNELS_DEF       = 3;
   localparam int TEMPORAL_DEPTH_DEF = 2;
   localparam int PATCH_SIDE_DEF     = 16;

   // Fixed field widths.
   localparam int FUNC_W  = 2;
   localparam int INDEX_W = 17;
   localparam int VALUE_W = 32;
   localparam int PIX_W   = 16;
   localparam int PROD_W  = 2 * PIX_W;
   localparam int BIAS_W  = 32;
   localparam int ACC_W   = 48;
   localparam int CHAN_W  = 6;

   // Configuration port.
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;
   localparam int REG_IDX_W  = CSR_AW - 2;
   localparam logic [REG_IDX_W-1:0] REG_BIAS_EN = '0;

   // Input item function codes.
   localparam logic [FUNC_W-1:0] FUNC_LOAD_WEIGHT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_BIAS   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_ACCUM       = 2'd2;

   // Commands from the sequencer to the MAC datapath.
   typedef struct packed {
      logic wr_en;    // write one weight word
      logic issue;    // start one multiply-accumulate
      logic acc_clr;  // zero every accumulator
   } mac_cmd_type;

endpackage

// ===== sv/pem_mac.sv =====
// Shared MAC datapath: weight store, one 16x16 multiplier, accumulator store.
// Depends on pem_pkg; driven by pem_ctrl.
module pem_mac #(
   parameter int PROJ_CH   = pem_pkg::PROJ_CH_DEF,
   parameter int PLEN      = pem_pkg::CHANNELS_DEF * pem_pkg::TEMPORAL_DEPTH_DEF
                             * pem_pkg::PATCH_SIDE_DEF * pem_pkg::PATCH_SIDE_DEF,
   parameter int WDEPTH    = PROJ_CH * PLEN,
   parameter int WA_W      = $clog2(WDEPTH),
   parameter int CH_W      = (PROJ_CH > 1) ? $clog2(PROJ_CH) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pem_pkg::mac_cmd_type              cmd,
   input  logic [WA_W-1:0]                   wr_addr,
   input  logic [pem_pkg::PIX_W-1:0]         wr_data,
   input  logic [WA_W-1:0]                   rd_addr,
   input  logic [CH_W-1:0]                   ch,
   input  logic [pem_pkg::PIX_W-1:0]         px,
   output logic [pem_pkg::ACC_W-1:0]         acc_q,
   output logic                              busy
);
   import pem_pkg::*;

   logic [PIX_W-1:0]  weight_mem [WDEPTH];
   logic [ACC_W-1:0]  acc_mem [PROJ_CH];
   logic [PROJ_CH-1:0] acc_vld_ff;

   logic signed [PIX_W-1:0] w_rd_ff;
   logic signed [PIX_W-1:0] s1_px_ff;
   logic [ACC_W-1:0]  acc_rd_ff;
   logic              acc_rv_ff;
   logic [CH_W-1:0]   s1_ch_ff;
   logic              s1_vld_ff;

   logic signed [PROD_W-1:0] prod_ff;
   logic [ACC_W-1:0]  s2_acc_ff;
   logic [CH_W-1:0]   s2_ch_ff;
   logic              s2_vld_ff;

   logic [ACC_W-1:0]  acc_sum;

   // Weight store: one write port for loads, one registered read for the MAC.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         weight_mem[wr_addr] <= wr_data;
      end
      w_rd_ff <= weight_mem[rd_addr];
   end

   assign acc_sum = s2_acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   // Accumulator store: read at the sequencer's channel, written back from stage s2.
   always_ff @(posedge clock) begin
      if (s2_vld_ff) begin
         acc_mem[s2_ch_ff] <= acc_sum;
      end
      acc_rd_ff <= acc_mem[ch];
      acc_rv_ff <= acc_vld_ff[ch];
   end

   // An entry without its valid bit reads as zero.
   always_ff @(posedge clock) begin
      if (reset || cmd.acc_clr) begin
         acc_vld_ff <= '0;
      end else if (s2_vld_ff) begin
         acc_vld_ff[s2_ch_ff] <= 1'b1;
      end
   end

   assign acc_q = acc_rv_ff ? acc_rd_ff : '0;

   // Multiply pipeline: stage s1 holds pixel and channel, stage s2 the product, the read accumulator and the channel.
   always_ff @(posedge clock) begin
      s1_px_ff  <= px;
      s1_ch_ff  <= ch;
      prod_ff   <= s1_px_ff * w_rd_ff;
      s2_acc_ff <= acc_q;
      s2_ch_ff  <= s1_ch_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.issue;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   assign busy = s1_vld_ff | s2_vld_ff;

   a_clr_not_during_writeback: assert property (@(posedge clock) disable iff (reset)
      cmd.acc_clr |-> !s2_vld_ff)
      else $error("accumulator clear collides with a write-back");

   a_issue_not_with_load: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !cmd.wr_en)
      else $error("weight load during a MAC pass");

   a_issue_not_with_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> !cmd.acc_clr)
      else $error("accumulator clear during a MAC pass");

endmodule

// ===== sv/pem_ctrl.sv =====
// Sequencer: takes input transactions, walks the channels through the MAC,
// holds the bias store and the result register. Depends on pem_pkg.
module pem_ctrl #(
   parameter int PROJ_CH   = pem_pkg::PROJ_CH_DEF,
   parameter int PLEN      = pem_pkg::CHANNELS_DEF * pem_pkg::TEMPORAL_DEPTH_DEF
                             * pem_pkg::PATCH_SIDE_DEF * pem_pkg::PATCH_SIDE_DEF,
   parameter int WDEPTH    = PROJ_CH * PLEN,
   parameter int WA_W      = $clog2(WDEPTH),
   parameter int CH_W      = (PROJ_CH > 1) ? $clog2(PROJ_CH) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              bias_en,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [pem_pkg::FUNC_W-1:0]        req_func,
   input  logic [pem_pkg::INDEX_W-1:0]       req_index,
   input  logic [pem_pkg::VALUE_W-1:0]       req_value,
   input  logic                              req_patch_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pem_pkg::CHAN_W-1:0]        rsp_channel,
   output logic signed [pem_pkg::ACC_W-1:0]  rsp_embedding,
   output logic                              rsp_last_channel,
   output pem_pkg::mac_cmd_type              cmd,
   output logic [WA_W-1:0]                   wr_addr,
   output logic [pem_pkg::PIX_W-1:0]         wr_data,
   output logic [WA_W-1:0]                   rd_addr,
   output logic [CH_W-1:0]                   ch,
   output logic [pem_pkg::PIX_W-1:0]         px,
   input  logic [pem_pkg::ACC_W-1:0]         acc_q,
   input  logic                              mac_busy
);
   import pem_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_MAC   = 6'b000010,
      S_DRAIN = 6'b000100,
      S_EREAD = 6'b001000,
      S_ESUM  = 6'b010000,
      S_EOUT  = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [CH_W-1:0]    c_ff, c_in;
   logic [WA_W-1:0]    addr_ff, addr_in;
   logic [PIX_W-1:0]   px_ff, px_in;
   logic               last_ff, last_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]  rsp_channel_ff, rsp_channel_in;
   logic [ACC_W-1:0]   rsp_embedding_ff, rsp_embedding_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [BIAS_W-1:0]    bias_mem [PROJ_CH];
   logic [PROJ_CH-1:0]   bias_vld_ff;
   logic [BIAS_W-1:0]    bias_rd_ff;
   logic                 bias_rv_ff;

   logic               req_accept;
   logic               bias_we;
   logic               pos_ok;
   logic               c_last;
   logic [ACC_W-1:0]   bias_ext;

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid & req_ready;
   assign pos_ok     = 32'(req_index) < 32'(PLEN);
   assign bias_we    = req_accept && (req_func == FUNC_LOAD_BIAS)
                       && (32'(req_index) < 32'(PROJ_CH));
   assign c_last     = (c_ff == CH_W'(PROJ_CH - 1));

   // Bias store with a valid bit per channel; an unwritten channel reads as zero.
   always_ff @(posedge clock) begin
      if (bias_we) begin
         bias_mem[CH_W'(req_index)] <= req_value;
      end
      bias_rd_ff <= bias_mem[c_ff];
      bias_rv_ff <= bias_vld_ff[c_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_vld_ff <= '0;
      end else if (bias_we) begin
         bias_vld_ff[CH_W'(req_index)] <= 1'b1;
      end
   end

   assign bias_ext = (bias_en && bias_rv_ff)
                     ? {{(ACC_W-BIAS_W){bias_rd_ff[BIAS_W-1]}}, bias_rd_ff} : '0;

   // Datapath commands.
   assign wr_addr = WA_W'(req_index);
   assign wr_data = req_value[PIX_W-1:0];
   assign rd_addr = addr_ff;
   assign ch      = c_ff;
   assign px      = px_ff;

   always_comb begin
      state_in         = state_ff;
      c_in             = c_ff;
      addr_in          = addr_ff;
      px_in            = px_ff;
      last_in          = last_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_channel_in   = rsp_channel_ff;
      rsp_embedding_in = rsp_embedding_ff;
      rsp_last_in      = rsp_last_ff;
      cmd              = '0;
      cmd.wr_en        = req_accept && (req_func == FUNC_LOAD_WEIGHT)
                         && (32'(req_index) < 32'(WDEPTH));
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_func == FUNC_ACCUM)) begin
               c_in    = '0;
               last_in = req_patch_last;
               if (pos_ok) begin
                  px_in    = req_value[PIX_W-1:0];
                  addr_in  = WA_W'(req_index);
                  state_in = S_MAC;
               end else if (req_patch_last) begin
                  // out-of-patch position: add nothing, still close the patch
                  state_in = S_EREAD;
               end
            end
         end
         S_MAC: begin
            cmd.issue = 1'b1;
            addr_in   = addr_ff + WA_W'(PLEN);
            c_in      = c_ff + 1'b1;
            if (c_last) begin
               c_in     = '0;
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // hold until the last write-back has landed
            if (!mac_busy) begin
               state_in = last_ff ? S_EREAD : S_IDLE;
            end
         end
         S_EREAD: begin
            state_in = S_ESUM;
         end
         S_ESUM: begin
            rsp_valid_in     = 1'b1;
            rsp_channel_in   = CHAN_W'(c_ff);
            rsp_embedding_in = acc_q + bias_ext;
            rsp_last_in      = c_last;
            state_in         = S_EOUT;
         end
         S_EOUT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (c_last) begin
                  cmd.acc_clr = 1'b1;
                  c_in        = '0;
                  state_in    = S_IDLE;
               end else begin
                  c_in     = c_ff + 1'b1;
                  state_in = S_EREAD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         c_ff         <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         c_ff         <= c_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff          <= addr_in;
      px_ff            <= px_in;
      rsp_channel_ff   <= rsp_channel_in;
      rsp_embedding_ff <= rsp_embedding_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_channel      = rsp_channel_ff;
   assign rsp_embedding    = rsp_embedding_ff;
   assign rsp_last_channel = rsp_last_ff;

   a_eout_has_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EOUT) |-> rsp_valid_ff)
      else $error("result state without a pending result");

   a_no_intake_while_emitting: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_ready)
      else $error("input taken while a result is pending");

   a_emit_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EREAD) |-> !mac_busy)
      else $error("accumulator read before the MAC pipeline drained");

endmodule

// ===== sv/patch_embedding_mac.sv =====
// Patch embedding MAC: an accumulate item runs one MAC per channel through the
// shared multiplier, then drains the multiply and write-back stages; the input
// is not ready meanwhile, so a new accumulate transaction waits until it is done.
// Weight and bias loads are taken while idle. A patch end emits PROJ_CH channel
// results, each through accumulator read, bias add and output register.
// Reset: bias_enable=1, bias and accumulators read as zero; weights stay unset.
module patch_embedding_mac #(
   parameter int PROJ_CH        = pem_pkg::PROJ_CH_DEF,
   parameter int CHANNELS       = pem_pkg::CHANNELS_DEF,
   parameter int TEMPORAL_DEPTH = pem_pkg::TEMPORAL_DEPTH_DEF,
   parameter int PATCH_SIDE     = pem_pkg::PATCH_SIDE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [pem_pkg::FUNC_W-1:0]        req_func,
   input  logic [pem_pkg::INDEX_W-1:0]       req_index,
   input  logic signed [pem_pkg::VALUE_W-1:0] req_value,
   input  logic                              req_patch_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pem_pkg::CHAN_W-1:0]        rsp_channel,
   output logic signed [pem_pkg::ACC_W-1:0]  rsp_embedding,
   output logic                              rsp_last_channel,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pem_pkg::CSR_AW-1:0]        csr_paddr,
   input  logic [pem_pkg::CSR_DW-1:0]        csr_pwdata,
   output logic [pem_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                              csr_pready
);
   import pem_pkg::*;

   localparam int PLEN   = CHANNELS * TEMPORAL_DEPTH * PATCH_SIDE * PATCH_SIDE;
   localparam int WDEPTH = PROJ_CH * PLEN;
   localparam int WA_W   = $clog2(WDEPTH);
   localparam int CH_W   = (PROJ_CH > 1) ? $clog2(PROJ_CH) : 1;

   logic               bias_en_ff;
   logic               csr_wr;
   logic               reg_hit;
   mac_cmd_type        cmd;
   logic [WA_W-1:0]    wr_addr;
   logic [PIX_W-1:0]   wr_data;
   logic [WA_W-1:0]    rd_addr;
   logic [CH_W-1:0]    ch;
   logic [PIX_W-1:0]   px;
   logic [ACC_W-1:0]   acc_q;
   logic               mac_busy;

   // Configuration register file.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_hit    = (csr_paddr[CSR_AW-1:2] == REG_BIAS_EN);

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_en_ff <= 1'b1;
      end else if (csr_wr && reg_hit) begin
         bias_en_ff <= csr_pwdata[0];
      end
   end

   assign csr_prdata = reg_hit ? {{(CSR_DW-1){1'b0}}, bias_en_ff} : '0;

   pem_ctrl #(
      .PROJ_CH   (PROJ_CH),
      .PLEN      (PLEN),
      .WDEPTH    (WDEPTH),
      .WA_W      (WA_W),
      .CH_W      (CH_W)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .bias_en          (bias_en_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_index        (req_index),
      .req_value        (req_value),
      .req_patch_last   (req_patch_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_channel      (rsp_channel),
      .rsp_embedding    (rsp_embedding),
      .rsp_last_channel (rsp_last_channel),
      .cmd              (cmd),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rd_addr          (rd_addr),
      .ch               (ch),
      .px               (px),
      .acc_q            (acc_q),
      .mac_busy         (mac_busy)
   );

   pem_mac #(
      .PROJ_CH   (PROJ_CH),
      .PLEN      (PLEN),
      .WDEPTH    (WDEPTH),
      .WA_W      (WA_W),
      .CH_W      (CH_W)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .ch      (ch),
      .px      (px),
      .acc_q   (acc_q),
      .busy    (mac_busy)
   );

endmodule
